/* design/efc_pkg.sv */
// Shared types, constants and character helpers for the expression field classifier.
// No dependencies; imported by efc_scanner, efc_result_fifo and the top level.
package efc_pkg;

  // Scanner phases between and inside fields
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_STR,
    PH_ALPHA1,
    PH_VAR_AFTER,
    PH_VAR_SUFFIX,
    PH_FUNC_NAME,
    PH_FUNC_SUFFIX,
    PH_FUNC_BODY,
    PH_FUNC_CLOSE,
    PH_ARRAY_BODY,
    PH_ARRAY_CLOSE,
    PH_NUM_INT,
    PH_NUM_FRAC,
    PH_NUM_TAIL,
    PH_NUM_ESIGN,
    PH_NUM_EDIG1,
    PH_NUM_EDIG
  } phase_t;

  // Field class codes
  localparam logic [3:0] CLS_STRING      = 4'd0;
  localparam logic [3:0] CLS_FUNC        = 4'd1;
  localparam logic [3:0] CLS_STR_FUNC    = 4'd2;
  localparam logic [3:0] CLS_VAR         = 4'd3;
  localparam logic [3:0] CLS_STR_VAR     = 4'd4;
  localparam logic [3:0] CLS_ARRAY       = 4'd5;
  localparam logic [3:0] CLS_STR_ARRAY   = 4'd6;
  localparam logic [3:0] CLS_NUMBER      = 4'd7;
  localparam logic [3:0] CLS_OPERATOR    = 4'd8;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_KEYMAX = 8'h1f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;

  // Field length cap: lesser of the length bound and the 8-bit field
  localparam int MAX_LENGTH = 255;
  localparam logic [7:0] LEN_CAP = (MAX_LENGTH < 255) ? 8'(MAX_LENGTH) : 8'd255;

  // Result queue depth (power of two)
  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic [3:0] field_class;
    logic       is_error;
    logic [7:0] field_length;
    logic       last;
  } result_t;

  // Up to two results pushed per processed character
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_lower(logic [7:0] c);
    return (c >= CH_LOW_A) && (c <= CH_LOW_Z);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == CH_CARET) || (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PLUS) ||
           (c == CH_MINUS) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c <= CH_KEYMAX) || (c == CH_SPACE) || (c == CH_CARET) || (c == CH_STAR) ||
           (c == CH_PLUS) || (c == CH_SLASH) || (c == CH_MINUS) || (c == CH_RPAREN);
  endfunction

  function automatic logic [7:0] bump_count(logic [7:0] cnt);
    return (cnt < LEN_CAP) ? cnt + 8'd1 : cnt;
  endfunction

endpackage

/* design/efc_scanner.sv */
// Field scanner: holds the scan state and turns one character into up to two results.
// Depends on efc_pkg.
module efc_scanner #(
  parameter int MAX_DEPTH = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       character,
  input  logic             strings_enabled,
  output efc_pkg::push_t   push
);
  import efc_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);
  // longest lookahead chain within one character takes four passes
  // (name start, suffix check, delimiter, new field)
  localparam int PASSES = 4;

  typedef struct packed {
    phase_t        phase;
    logic [DW-1:0] depth;
    logic [7:0]    count;
    logic          suffix;
  } scan_state_t;

  typedef struct packed {
    scan_state_t st;
    logic        emit;
    result_t     res;
    logic        more;
    logic        skip;
  } step_t;

  scan_state_t st, st_next;
  logic        skip, skip_next;

  // One pass of the phase machine; emit clears the field state afterwards
  function automatic step_t step_fn(scan_state_t s, logic [7:0] c, logic se);
    step_t      o;
    logic       ec;
    logic       err;
    logic [3:0] cls;
    logic [3:0] bcls;
    phase_t     bclose;
    o = '0;
    o.st = s;
    ec = 1'b0;
    err = 1'b0;
    cls = CLS_OPERATOR;
    bcls = CLS_FUNC;
    bclose = PH_FUNC_CLOSE;
    unique case (s.phase)
      PH_IDLE: begin
        if (c == CH_NUL) begin
          o.st.phase = PH_IDLE;
        end else if (c == CH_QUOTE && se) begin
          o.st.phase = PH_STR;
        end else if (is_lower(c)) begin
          o.st.count = bump_count(s.count);
          o.st.phase = PH_ALPHA1;
        end else if (is_digit(c) || c == CH_DOT) begin
          o.st.count = bump_count(s.count);
          o.st.phase = PH_NUM_INT;
        end else if (is_op(c)) begin
          o.st.count = bump_count(s.count);
          ec = 1'b1;
        end else begin
          ec = 1'b1; err = 1'b1;
        end
      end
      PH_STR: begin
        cls = CLS_STRING;
        if (c == CH_QUOTE) begin
          ec = 1'b1;
        end else if (c == CH_NUL) begin
          ec = 1'b1; err = 1'b1;
        end else begin
          o.st.count = bump_count(s.count);
        end
      end
      PH_ALPHA1: begin
        if (is_lower(c)) begin
          o.st.count = bump_count(s.count);
          o.st.phase = PH_FUNC_NAME;
        end else if (is_digit(c)) begin
          o.st.count = bump_count(s.count);
          o.st.phase = PH_VAR_AFTER;
        end else begin
          o.st.phase = PH_VAR_AFTER;
          o.more = 1'b1;
        end
      end
      PH_VAR_AFTER: begin
        if (c == CH_DOLLAR && se) begin
          o.st.count = bump_count(s.count);
          o.st.suffix = 1'b1;
          o.st.phase = PH_VAR_SUFFIX;
        end else begin
          o.st.phase = PH_VAR_SUFFIX;
          o.more = 1'b1;
        end
      end
      PH_VAR_SUFFIX: begin
        cls = s.suffix ? CLS_STR_VAR : CLS_VAR;
        if (c == CH_LPAREN) begin
          o.st.count = bump_count(s.count);
          o.st.depth = DW'(1);
          o.st.phase = PH_ARRAY_BODY;
        end else if (is_delim(c)) begin
          ec = 1'b1; o.more = 1'b1;
        end else begin
          ec = 1'b1; err = 1'b1;
        end
      end
      PH_FUNC_NAME: begin
        if (is_lower(c) || is_digit(c)) begin
          o.st.count = bump_count(s.count);
        end else if (c == CH_DOLLAR && se) begin
          o.st.count = bump_count(s.count);
          o.st.suffix = 1'b1;
          o.st.phase = PH_FUNC_SUFFIX;
        end else begin
          o.st.phase = PH_FUNC_SUFFIX;
          o.more = 1'b1;
        end
      end
      PH_FUNC_SUFFIX: begin
        cls = CLS_FUNC;
        if (c == CH_LPAREN) begin
          o.st.count = bump_count(s.count);
          o.st.depth = DW'(1);
          o.st.phase = PH_FUNC_BODY;
        end else begin
          ec = 1'b1; err = 1'b1;
        end
      end
      PH_FUNC_BODY, PH_ARRAY_BODY: begin
        // balanced parens; the closing one moves on to the delimiter check
        if (s.phase == PH_ARRAY_BODY) begin
          bcls = s.suffix ? CLS_STR_ARRAY : CLS_ARRAY;
          bclose = PH_ARRAY_CLOSE;
        end else begin
          bcls = s.suffix ? CLS_STR_FUNC : CLS_FUNC;
          bclose = PH_FUNC_CLOSE;
        end
        cls = bcls;
        if (c == CH_NUL) begin
          ec = 1'b1; err = 1'b1;
        end else if (c == CH_LPAREN && s.depth >= DEPTH_MAX) begin
          ec = 1'b1; err = 1'b1;
        end else begin
          if (c == CH_LPAREN) begin
            o.st.depth = s.depth + DW'(1);
          end else if (c == CH_RPAREN) begin
            o.st.depth = s.depth - DW'(1);
          end
          o.st.count = bump_count(s.count);
          if (o.st.depth == '0) begin
            o.st.phase = bclose;
          end
        end
      end
      PH_FUNC_CLOSE: begin
        if (is_delim(c)) begin
          cls = s.suffix ? CLS_STR_FUNC : CLS_FUNC;
          ec = 1'b1; o.more = 1'b1;
        end else begin
          cls = CLS_FUNC;
          ec = 1'b1; err = 1'b1;
        end
      end
      PH_ARRAY_CLOSE: begin
        cls = s.suffix ? CLS_STR_ARRAY : CLS_ARRAY;
        if (is_delim(c)) begin
          ec = 1'b1; o.more = 1'b1;
        end else begin
          ec = 1'b1; err = 1'b1;
        end
      end
      PH_NUM_INT: begin
        if (is_digit(c)) begin
          o.st.count = bump_count(s.count);
        end else if (c == CH_DOT) begin
          o.st.count = bump_count(s.count);
          o.st.phase = PH_NUM_FRAC;
        end else begin
          o.st.phase = PH_NUM_TAIL;
          o.more = 1'b1;
        end
      end
      PH_NUM_FRAC: begin
        if (is_digit(c)) begin
          o.st.count = bump_count(s.count);
        end else begin
          o.st.phase = PH_NUM_TAIL;
          o.more = 1'b1;
        end
      end
      PH_NUM_TAIL: begin
        cls = CLS_NUMBER;
        if (c == CH_LOW_E || c == CH_UP_E) begin
          o.st.count = bump_count(s.count);
          o.st.phase = PH_NUM_ESIGN;
        end else if (is_delim(c)) begin
          ec = 1'b1; o.more = 1'b1;
        end else begin
          ec = 1'b1; err = 1'b1;
        end
      end
      PH_NUM_ESIGN: begin
        cls = CLS_NUMBER;
        if (c == CH_PLUS || c == CH_MINUS) begin
          o.st.count = bump_count(s.count);
          o.st.phase = PH_NUM_EDIG1;
        end else begin
          ec = 1'b1; err = 1'b1;
        end
      end
      PH_NUM_EDIG1: begin
        cls = CLS_NUMBER;
        if (is_digit(c)) begin
          o.st.count = bump_count(s.count);
          o.st.phase = PH_NUM_EDIG;
        end else begin
          ec = 1'b1; err = 1'b1;
        end
      end
      PH_NUM_EDIG: begin
        cls = CLS_NUMBER;
        if (is_digit(c)) begin
          o.st.count = bump_count(s.count);
        end else if (is_delim(c)) begin
          ec = 1'b1; o.more = 1'b1;
        end else begin
          ec = 1'b1; err = 1'b1;
        end
      end
      default: begin
        o.st.phase = PH_IDLE;
        o.more = 1'b1;
      end
    endcase
    // report the field and start over between fields
    if (ec) begin
      o.emit = 1'b1;
      o.res.field_class = cls;
      o.res.is_error = err;
      o.res.field_length = o.st.count;
      o.res.last = 1'b0;
      o.skip = err && (c != CH_NUL);
      o.st.count = '0;
      o.st.depth = '0;
      o.st.suffix = 1'b0;
      o.st.phase = PH_IDLE;
    end
    return o;
  endfunction

  // Chain of lookahead passes for the current character
  always_comb begin
    scan_state_t cur;
    step_t       so;
    logic        active;
    logic [1:0]  n;
    result_t     r0, r1;
    cur = st;
    so = '0;
    active = fire && !skip;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    skip_next = skip;
    if (fire && skip && character == CH_NUL) begin
      skip_next = 1'b0;
    end
    for (int p = 0; p < PASSES; p++) begin
      if (active) begin
        so = step_fn(cur, character, strings_enabled);
        if (so.emit) begin
          if (n == 2'd0) begin
            r0 = so.res;
          end else begin
            r1 = so.res;
          end
          n = n + 2'd1;
        end
        if (so.skip) begin
          skip_next = 1'b1;
        end
        cur = so.st;
        active = so.more;
      end
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
    st_next = cur;
    push.n = n;
    push.r0 = r0;
    push.r1 = r1;
  end

  // Scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_IDLE;
      st.depth <= '0;
      st.count <= '0;
      st.suffix <= 1'b0;
      skip <= 1'b0;
    end else if (fire) begin
      st <= st_next;
      skip <= skip_next;
    end
  end

  a_skip_idle: assert property (@(posedge clk) disable iff (rst)
    skip |-> st.phase == PH_IDLE)
    else $error("skip active outside the idle phase");

  a_depth_body: assert property (@(posedge clk) disable iff (rst)
    (st.depth != '0) |-> (st.phase == PH_FUNC_BODY || st.phase == PH_ARRAY_BODY))
    else $error("paren depth held outside a paren body");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_IDLE) |-> (st.count == '0 && !st.suffix))
    else $error("field state not cleared between fields");

endmodule

/* design/efc_result_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on efc_pkg.
module efc_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  efc_pkg::push_t    push,
  input  logic              pop,
  output logic              space2,
  output logic              nonempty,
  output efc_pkg::result_t  head
);
  import efc_pkg::*;

  localparam int PW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  result_t        mem [RES_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  cnt, cnt_next;

  assign space2   = cnt <= CW'(RES_DEPTH - 2);
  assign nonempty = cnt != '0;
  assign head     = mem[rd_ptr];
  assign cnt_next = cnt + CW'(push.n) - CW'(pop);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      cnt <= cnt_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (cnt + CW'(push.n) - CW'(pop) <= CW'(RES_DEPTH)))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from empty result queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> cnt == $past(cnt_next))
    else $error("fill count lost track of transfers");

endmodule

/* design/expression_field_classifier.sv */
// Top level of the expression field classifier: input register, scanner, result queue.
// Depends on efc_pkg, efc_scanner and efc_result_fifo.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | character
//  out      | out_valid / out_stall| field_class, is_error, field_length, last
//  cfg      | cfg_valid / cfg_ready| strings_enabled
//
// One character is taken per cycle while in_stall is low; its results pass through
// the input register, then the scanner into the result queue, before the output.
// A character with two results is handed out as two transfers; the four-entry queue
// absorbs that, and in_stall rises only when the queue lacks room for two.
// Synchronous reset clears the scan state and empties the queue; no clearing pass.
// out_stall holds the head result; cfg writes are always ready.
module expression_field_classifier #(
  parameter int MAX_DEPTH = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] character,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] field_class,
  output logic       is_error,
  output logic [7:0] field_length,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       strings_enabled
);
  import efc_pkg::*;

  logic       ireg_valid;
  logic [7:0] ireg_char;
  logic       se_reg;
  logic       space2;
  logic       fire;
  logic       pop;
  push_t      push;
  result_t    head;

  assign fire      = ireg_valid && space2;
  assign in_stall  = ireg_valid && !space2;
  assign pop       = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  assign field_class  = head.field_class;
  assign is_error     = head.is_error;
  assign field_length = head.field_length;
  assign last         = head.last;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      se_reg <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      se_reg <= strings_enabled;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (!in_stall) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ireg_char <= character;
    end
  end

  efc_scanner #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_scanner (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .character      (ireg_char),
    .strings_enabled(se_reg),
    .push           (push)
  );

  efc_result_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (pop),
    .space2  (space2),
    .nonempty(out_valid),
    .head    (head)
  );

  a_push_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> fire)
    else $error("results pushed without a processed character");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    $past(in_stall) |-> (ireg_valid && $stable(ireg_char)))
    else $error("input register changed while stalled");

  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (!push.r0.last && push.r1.last))
    else $error("last flag misplaced on a two-result character");

endmodule
